### src/qrm_pkg.sv
// Shared constants for the quaternion to rotation matrix core.
// No dependencies; used by every module of the core.
package qrm_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF   = 14;
    localparam int OUT_W               = 16;
    localparam int NUM_ELEM            = 9;

endpackage

### src/qrm_front.sv
// Front end: squares and cross products, numerator sums, sign and magnitude.
// Three register stages. Depends on qrm_pkg.
module qrm_front #(
    parameter int CW = qrm_pkg::COMPONENT_WIDTH_DEF,
    parameter int NW = 2 * CW + 2
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] quat_w,
    input  logic signed [CW-1:0] quat_x,
    input  logic signed [CW-1:0] quat_y,
    input  logic signed [CW-1:0] quat_z,
    output logic [NW-1:0]        n,
    output logic [NW-1:0]        mag [qrm_pkg::NUM_ELEM],
    output logic                 neg [qrm_pkg::NUM_ELEM],
    output logic                 zero
);
    localparam int PW = 2 * CW;

    logic signed [CW-1:0] w, x, y, z;
    logic                 all_eq;

    logic [PW-1:0]        sq_reg [4];
    logic signed [PW-1:0] pr_reg [6];
    logic                 zero1_reg;

    logic [NW-1:0]          n2_reg;
    logic [PW:0]            a_reg [3];
    logic [PW:0]            b_reg [3];
    logic signed [PW:0]     d_reg [6];
    logic                   zero2_reg;

    logic [NW-1:0] n3_reg;
    logic [NW-1:0] mag_reg [qrm_pkg::NUM_ELEM];
    logic          neg_reg [qrm_pkg::NUM_ELEM];
    logic          zero3_reg;

    logic signed [PW:0] ext [6];

    // A quaternion with all four components equal is the same rotation as (1,1,1,1).
    assign all_eq = (quat_w == quat_x) && (quat_x == quat_y) && (quat_y == quat_z)
                    && (quat_w != '0);

    always_comb
    begin
        if (all_eq)
        begin
            w = CW'(1);
            x = CW'(1);
            y = CW'(1);
            z = CW'(1);
        end
        else
        begin
            w = quat_w;
            x = quat_x;
            y = quat_y;
            z = quat_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= PW'(w * w);
            sq_reg[1] <= PW'(x * x);
            sq_reg[2] <= PW'(y * y);
            sq_reg[3] <= PW'(z * z);
            pr_reg[0] <= x * y;
            pr_reg[1] <= x * z;
            pr_reg[2] <= y * z;
            pr_reg[3] <= w * z;
            pr_reg[4] <= w * y;
            pr_reg[5] <= w * x;
            zero1_reg <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0)
                         && (quat_z == '0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ext[i] = {pr_reg[i][PW-1], pr_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg    <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]) + NW'(sq_reg[3]);
            a_reg[0]  <= (PW+1)'(sq_reg[0]) + (PW+1)'(sq_reg[1]);
            b_reg[0]  <= (PW+1)'(sq_reg[2]) + (PW+1)'(sq_reg[3]);
            a_reg[1]  <= (PW+1)'(sq_reg[0]) + (PW+1)'(sq_reg[2]);
            b_reg[1]  <= (PW+1)'(sq_reg[1]) + (PW+1)'(sq_reg[3]);
            a_reg[2]  <= (PW+1)'(sq_reg[0]) + (PW+1)'(sq_reg[3]);
            b_reg[2]  <= (PW+1)'(sq_reg[1]) + (PW+1)'(sq_reg[2]);
            d_reg[0]  <= ext[0] - ext[3];
            d_reg[1]  <= ext[1] + ext[4];
            d_reg[2]  <= ext[0] + ext[3];
            d_reg[3]  <= ext[2] - ext[5];
            d_reg[4]  <= ext[1] - ext[4];
            d_reg[5]  <= ext[2] + ext[5];
            zero2_reg <= zero1_reg;
        end
    end

    function automatic logic [NW-1:0] cross_mag(input logic signed [PW:0] d);
        logic [PW:0] m;
        m = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
        return NW'({m, 1'b0});
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n3_reg    <= n2_reg;
            zero3_reg <= zero2_reg;
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[4*k] <= a_reg[k] < b_reg[k];
                mag_reg[4*k] <= (a_reg[k] >= b_reg[k]) ? {1'b0, a_reg[k] - b_reg[k]}
                                                       : {1'b0, b_reg[k] - a_reg[k]};
            end
            neg_reg[1] <= d_reg[0][PW];
            mag_reg[1] <= cross_mag(d_reg[0]);
            neg_reg[2] <= d_reg[1][PW];
            mag_reg[2] <= cross_mag(d_reg[1]);
            neg_reg[3] <= d_reg[2][PW];
            mag_reg[3] <= cross_mag(d_reg[2]);
            neg_reg[5] <= d_reg[3][PW];
            mag_reg[5] <= cross_mag(d_reg[3]);
            neg_reg[6] <= d_reg[4][PW];
            mag_reg[6] <= cross_mag(d_reg[4]);
            neg_reg[7] <= d_reg[5][PW];
            mag_reg[7] <= cross_mag(d_reg[5]);
        end
    end

    assign n    = n3_reg;
    assign mag  = mag_reg;
    assign neg  = neg_reg;
    assign zero = zero3_reg;

endmodule

### src/qrm_divider.sv
// Pipelined restoring divider giving round(mag * 2^F / n), one quotient bit per stage.
// F + 2 register stages. Depends on qrm_pkg for defaults only.
module qrm_divider #(
    parameter int NW = 2 * qrm_pkg::COMPONENT_WIDTH_DEF + 2,
    parameter int F  = qrm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] n,
    input  logic [NW-1:0] mag,
    input  logic          neg,
    output logic [F+1:0]  q,
    output logic          q_neg
);
    localparam int QW = F + 2;

    logic [NW-1:0] r_reg   [F+1];
    logic [NW-1:0] n_reg   [F+1];
    logic [QW-1:0] q_reg   [F+2];
    logic          neg_reg [F+2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= (mag >= n) ? mag - n : mag;
            q_reg[0]   <= QW'(mag >= n);
            n_reg[0]   <= n;
            neg_reg[0] <= neg;
        end
    end

    for (genvar i = 1; i <= F + 1; i++)
    begin : g_step
        logic [NW:0] r2;
        logic        ge;

        assign r2 = {r_reg[i-1], 1'b0};
        assign ge = r2 >= {1'b0, n_reg[i-1]};

        if (i <= F)
        begin : g_bit
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[i]   <= ge ? NW'(r2 - {1'b0, n_reg[i-1]}) : NW'(r2);
                    q_reg[i]   <= {q_reg[i-1][QW-2:0], ge};
                    n_reg[i]   <= n_reg[i-1];
                    neg_reg[i] <= neg_reg[i-1];
                end
            end
        end
        else
        begin : g_round
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[i]   <= q_reg[i-1] + QW'(ge);
                    neg_reg[i] <= neg_reg[i-1];
                end
            end
        end
    end

    assign q     = q_reg[F+1];
    assign q_neg = neg_reg[F+1];

endmodule

### src/quaternion_to_rotation_matrix_core.sv
// Top level of the quaternion to rotation matrix core.
// Depends on qrm_pkg, qrm_front and qrm_divider.
//
// Takes one quaternion per cycle unless stalled and returns the nine elements of its normalized
// 3x3 rotation matrix in signed Q1.OUT_FRAC_BITS, rounded to nearest, ties away from zero. The
// pipeline is three front stages, the nine parallel dividers that resolve one quotient bit per
// stage plus a rounding stage, and the output register. A zero quaternion gives the identity
// matrix with the zero_quat flag (m_tuser) set. The whole pipeline stalls together while a
// result is held in the output register.
module quaternion_to_rotation_matrix_core #(
    parameter int COMPONENT_WIDTH = qrm_pkg::COMPONENT_WIDTH_DEF,
    parameter int OUT_FRAC_BITS   = qrm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // quat_w, quat_x, quat_y, quat_z, zero padding to whole bytes.
    input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22.
    output logic [qrm_pkg::NUM_ELEM*qrm_pkg::OUT_W-1:0] m_tdata,
    // zero_quat.
    output logic                                   m_tuser
);
    localparam int CW  = COMPONENT_WIDTH;
    localparam int F   = OUT_FRAC_BITS;
    localparam int NW  = 2 * CW + 2;
    localparam int QW  = F + 2;
    localparam int OW  = qrm_pkg::OUT_W;
    localparam int NE  = qrm_pkg::NUM_ELEM;
    localparam int LAT = F + 6;
    localparam logic [32:0] POS_MAX = 33'((1 << (OW - 1)) - 1);
    localparam logic [32:0] NEG_MAX = 33'(1 << (OW - 1));
    localparam logic [32:0] ONE_Q   = 33'(64'(1) << F);
    localparam logic [OW-1:0] ONE_OUT = (ONE_Q > POS_MAX) ? OW'(POS_MAX) : OW'(ONE_Q);

    logic          en;
    logic          vld_reg [LAT];
    logic [NW-1:0] n;
    logic [NW-1:0] mag [NE];
    logic          neg [NE];
    logic          zero;
    logic [QW-1:0] q [NE];
    logic          q_neg [NE];
    logic          zp_reg [F+2];
    logic [NE*OW-1:0] data_next, data_reg;
    logic          user_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    qrm_front #(.CW(CW), .NW(NW)) u_front (
        .clk    (clk),
        .en     (en),
        .quat_w (s_tdata[CW-1:0]),
        .quat_x (s_tdata[2*CW-1:CW]),
        .quat_y (s_tdata[3*CW-1:2*CW]),
        .quat_z (s_tdata[4*CW-1:3*CW]),
        .n      (n),
        .mag    (mag),
        .neg    (neg),
        .zero   (zero)
    );

    for (genvar e = 0; e < NE; e++)
    begin : g_div
        qrm_divider #(.NW(NW), .F(F)) u_div (
            .clk   (clk),
            .en    (en),
            .n     (n),
            .mag   (mag[e]),
            .neg   (neg[e]),
            .q     (q[e]),
            .q_neg (q_neg[e])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zp_reg[0] <= zero;
            for (int i = 1; i < F + 2; i++)
            begin
                zp_reg[i] <= zp_reg[i-1];
            end
        end
    end

    always_comb
    begin
        logic [32:0] qe;
        for (int e = 0; e < NE; e++)
        begin
            qe = 33'(q[e]);
            if (zp_reg[F+1])
            begin
                data_next[e*OW +: OW] = (e % 4 == 0) ? ONE_OUT : '0;
            end
            else if (q_neg[e])
            begin
                data_next[e*OW +: OW] = (qe >= NEG_MAX) ? OW'(NEG_MAX) : OW'(-qe);
            end
            else
            begin
                data_next[e*OW +: OW] = (qe >= POS_MAX) ? OW'(POS_MAX) : OW'(qe);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            user_reg <= zp_reg[F+1];
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

`ifndef ASSERT_OFF
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[OW-1:0] == ONE_OUT
            && m_tdata[OW +: OW] == '0 && m_tdata[3*OW +: OW] == '0
            && m_tdata[4*OW +: OW] == ONE_OUT && m_tdata[8*OW +: OW] == ONE_OUT)
        else $error("zero quaternion did not give the identity matrix");
`endif

endmodule

### dv/quaternion_to_rotation_matrix_core_tb.sv
// Testbench for quaternion_to_rotation_matrix_core: random and directed quaternions with
// idle and stall phases, checked against a bit-exact rotation matrix predictor.
// Depends on qrm_pkg and the core RTL.
module quaternion_to_rotation_matrix_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = qrm_pkg::COMPONENT_WIDTH_DEF;
    localparam int FB = qrm_pkg::OUT_FRAC_BITS_DEF;
    localparam int NUM_ELEM = qrm_pkg::NUM_ELEM;
    localparam int OUT_W = qrm_pkg::OUT_W;
    localparam int IN_W = ((4 * CW + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [NUM_ELEM*OUT_W-1:0] elems;
        logic                      zero_quat;
    } matrix_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [NUM_ELEM*OUT_W-1:0] m_tdata;
    logic m_tuser;

    logic [IN_W-1:0] quat_queue[$];
    matrix_t matrix_queue[$];
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_recv;
    bit stim_done;
    int error_count;
    int idle_cycles;

    quaternion_to_rotation_matrix_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic logic [63:0] round_quotient(logic [63:0] mag, logic [63:0] n);
        logic [63:0] q;
        logic [63:0] r;
        q = 0;
        r = mag;
        if (r >= n)
        begin
            q = 1;
            r = r - n;
        end
        for (int i = 0; i < FB; i++)
        begin
            q = q << 1;
            if (r >= n - r)
            begin
                q = q | 1;
                r = r - (n - r);
            end
            else
                r = r + r;
        end
        if (r >= n - r)
            q = q + 1;
        return q;
    endfunction

    function automatic logic [OUT_W-1:0] saturate(bit neg, logic [63:0] mag);
        longint hi;
        longint v;
        hi = (longint'(1) << (OUT_W - 1)) - 1;
        if (mag > hi + 1)
            mag = hi + 1;
        v = neg ? -longint'(mag) : longint'(mag);
        if (v > hi)
            v = hi;
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] diag_elem(logic [63:0] a, logic [63:0] b,
                                                   logic [63:0] n);
        if (a >= b)
            return saturate(0, round_quotient(a - b, n));
        return saturate(1, round_quotient(b - a, n));
    endfunction

    function automatic logic [OUT_W-1:0] cross_elem(longint d, logic [63:0] n);
        logic [63:0] m;
        m = (d < 0) ? -d : d;
        return saturate(d < 0, round_quotient(m + m, n));
    endfunction

    function automatic matrix_t predict_matrix(logic [IN_W-1:0] q);
        longint w;
        longint x;
        longint y;
        longint z;
        logic [63:0] w2;
        logic [63:0] x2;
        logic [63:0] y2;
        logic [63:0] z2;
        logic [63:0] n;
        logic [OUT_W-1:0] e[NUM_ELEM];
        matrix_t res;
        w = longint'($signed(q[CW-1:0]));
        x = longint'($signed(q[2*CW-1:CW]));
        y = longint'($signed(q[3*CW-1:2*CW]));
        z = longint'($signed(q[4*CW-1:3*CW]));
        if (w == x && x == y && y == z && w != 0)
        begin
            w = 1; x = 1; y = 1; z = 1;
        end
        w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
        n = w2 + x2 + y2 + z2;
        if (n == 0)
        begin
            for (int k = 0; k < NUM_ELEM; k++)
                e[k] = (k % 4 == 0) ? saturate(0, 64'd1 << FB) : '0;
            res.zero_quat = 1;
        end
        else
        begin
            e[0] = diag_elem(w2 + x2, y2 + z2, n);
            e[1] = cross_elem(x * y - w * z, n);
            e[2] = cross_elem(x * z + w * y, n);
            e[3] = cross_elem(x * y + w * z, n);
            e[4] = diag_elem(w2 + y2, x2 + z2, n);
            e[5] = cross_elem(y * z - w * x, n);
            e[6] = cross_elem(x * z - w * y, n);
            e[7] = cross_elem(y * z + w * x, n);
            e[8] = diag_elem(w2 + z2, x2 + y2, n);
            res.zero_quat = 0;
        end
        for (int k = 0; k < NUM_ELEM; k++)
            res.elems[k*OUT_W +: OUT_W] = e[k];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_quat(logic [CW-1:0] w, logic [CW-1:0] x,
                                                  logic [CW-1:0] y, logic [CW-1:0] z);
        logic [IN_W-1:0] v;
        v = '0;
        v[4*CW-1:0] = {z, y, x, w};
        return v;
    endfunction

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 7) - 4;
            1: return 16'h8000 + $urandom_range(0, 3);
            2: return 16'h7fff - $urandom_range(0, 3);
            3: return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 0;
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                matrix_queue.push_back(predict_matrix(s_tdata));
            if (quat_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tdata <= quat_queue.pop_front();
                s_tvalid <= 1;
            end
            else
                s_tvalid <= 0;
        end
    end

    always @(posedge clk)
    begin
        matrix_t exp_m;
        if (!rst_n)
            m_tready <= 0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (matrix_queue.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    error_count++;
                end
                else
                begin
                    exp_m = matrix_queue.pop_front();
                    for (int k = 0; k < NUM_ELEM; k++)
                        if (m_tdata[k*OUT_W +: OUT_W] !== exp_m.elems[k*OUT_W +: OUT_W])
                        begin
                            $error("r%0d%0d expected %0d actual %0d", k / 3, k % 3,
                                   $signed(exp_m.elems[k*OUT_W +: OUT_W]),
                                   $signed(m_tdata[k*OUT_W +: OUT_W]));
                            error_count++;
                        end
                    if (m_tuser !== exp_m.zero_quat)
                    begin
                        $error("zero_quat expected %0d actual %0d", exp_m.zero_quat, m_tuser);
                        error_count++;
                    end
                end
            end
            m_tready <= !hold_recv && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (quat_queue.size() != 0 || s_tvalid || matrix_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                logic [CW-1:0] c;
                c = rand_comp();
                quat_queue.push_back(pack_quat(c, c, c, c));
            end
            else
                quat_queue.push_back(pack_quat(rand_comp(), rand_comp(), rand_comp(),
                                               rand_comp()));
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        hold_recv = 0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Zero, all-equal, extremes, single axes and sign mixes.
        quat_queue.push_back(pack_quat(0, 0, 0, 0));
        quat_queue.push_back(pack_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        quat_queue.push_back(pack_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        quat_queue.push_back(pack_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff));
        quat_queue.push_back(pack_quat(16'h7fff, 0, 0, 0));
        quat_queue.push_back(pack_quat(0, 16'h8000, 0, 0));
        quat_queue.push_back(pack_quat(0, 0, 16'h7fff, 0));
        quat_queue.push_back(pack_quat(0, 0, 0, 16'h8000));
        quat_queue.push_back(pack_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
        quat_queue.push_back(pack_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        quat_queue.push_back(pack_quat(1, 1, 0, 0));
        quat_queue.push_back(pack_quat(1, 0, 1, 0));
        quat_queue.push_back(pack_quat(1, 0, 0, 1));
        quat_queue.push_back(pack_quat(1, 2, 3, 4));
        quat_queue.push_back(pack_quat(16'hffff, 2, 16'hfffd, 4));
        quat_queue.push_back(pack_quat(3, 0, 0, 0));
        quat_queue.push_back(pack_quat(1, 1, 1, 16'hffff));
        quat_queue.push_back(pack_quat(16'h8000, 0, 0, 0));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        run_random(100, 0, 0);
        run_random(100, 64, 0);
        run_random(100, 0, 64);
        run_random(100, 7, 7);

        // Long receiver hold-off while the sender keeps offering requests.
        hold_recv = 1;
        send_idle_pct = 0;
        for (int i = 0; i < 60; i++)
            quat_queue.push_back(pack_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
        repeat (200) @(posedge clk);
        hold_recv = 0;
        wait_drained();
        run_random(40, 7, 7);

        repeat (FB + 20) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
